/* src/mmau_pkg.sv */
// Shared constants, mode codes and threshold tables for the multi-mode activation unit.
package mmau_pkg;

    // Fixed-point format of the sample: fraction bits, and the constants in that format.
    localparam int FRAC_BITS = 8;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
    localparam int THREE_Q   = 3 << FRAC_BITS;
    localparam int SIX_Q     = 6 << FRAC_BITS;
    localparam int HS_BIAS   = THREE_Q + 3;
    localparam int LIMIT_MAG = 24 << FRAC_BITS;

    // Division by six of the hard sigmoid numerator (at most 1538) as a multiply by 2^16/6.
    localparam int HS_RECIP  = 10923;
    localparam int HS_SHIFT  = 16;
    localparam int HS_N_W    = 11;
    localparam int HS_P_W    = 25;

    // Threshold tables: entry i is the smallest magnitude whose rounded result reaches the
    // (i+1)th level above the table's base.
    localparam int THR_W      = 13;
    localparam int TAB_N      = 256;
    localparam int TAB_HALF   = TAB_N / 2;
    localparam int TAB_IDX_W  = 8;
    localparam int CNT_W      = 9;
    localparam int VAL_W      = 9;
    localparam int SRCH_STEPS = 9;

    // Weight of one fixed-point step as a real number.
    localparam real STEP_Q    = 1.0 / real'(ONE_Q);

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 3;
    localparam logic REG_IDX_MODE = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_RELU   = 3'd0,
        MODE_RELU6  = 3'd1,
        MODE_SIGM   = 3'd2,
        MODE_SILU   = 3'd3,
        MODE_HSIGM  = 3'd4,
        MODE_HSWISH = 3'd5,
        MODE_TANH   = 3'd6
    } act_mode_t;

    typedef logic [TAB_N-1:0][THR_W-1:0] thr_tab_t;

    // Builds a table at elaboration. Sigmoid uses only the lower half; the rest is padded
    // with a value above any magnitude that reaches the search.
    function automatic thr_tab_t build_thr(input logic tanh_sel);
        thr_tab_t tab;
        real      p;
        real      v;
        for (int i = 0; i < TAB_N; i++)
        begin
            if (tanh_sel)
            begin
                p = (real'(i) + 0.5) * STEP_Q;
                v = 0.5 * ($ln(1.0 + p) - $ln(1.0 - p));
                tab[i] = THR_W'(int'($ceil(v * real'(ONE_Q))));
            end
            else if (i < TAB_HALF)
            begin
                p = (real'(HALF_Q + i) + 0.5) * STEP_Q;
                v = $ln(p) - $ln(1.0 - p);
                tab[i] = THR_W'(int'($ceil(v * real'(ONE_Q))));
            end
            else
            begin
                tab[i] = '1;
            end
        end
        return tab;
    endfunction

    localparam thr_tab_t SIG_THR  = build_thr(1'b0);
    localparam thr_tab_t TANH_THR = build_thr(1'b1);

endpackage

/* src/multi_mode_activation_unit.sv */
// Top level of the multi-mode activation unit: APB mode register and 15-stage pipeline.
//
// The unit takes one signed fixed-point word (FRAC_BITS = 8 fraction bits) per clock and
// returns its activation under the mode register: relu, relu6, sigmoid, silu, hard sigmoid,
// hard swish or tanh (code 7 gives zero). A word is taken at every rising edge where start is
// high; busy is always low, since the pipeline never stalls. Every result is shown
// for one cycle, flagged by done, in the order the words came in, together with the word's
// last flag. Throughput is one word per cycle; the pipeline depth is set by the
// sigmoid/tanh lookup, which is a binary search over a 256-entry table of rounding
// thresholds spread over nine pipeline stages, followed by a multiply stage for
// silu and hard swish, a rounding stage and a saturating output register. Sigmoid and tanh
// are exact to the nearest step, ties away from zero; silu and hard swish round the product
// the same way. All results saturate to the signed DATA_WIDTH range. The mode register sits
// at byte address 0 and should be written only while no words are in flight.
module multi_mode_activation_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [DATA_WIDTH-1:0]           sample_in,
    input  logic                                   last_in,
    output logic                                   done,
    output logic signed [DATA_WIDTH-1:0]           sample_out,
    output logic                                   last_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mmau_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [mmau_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [mmau_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int DW     = DATA_WIDTH;
    localparam int RES_W  = DATA_WIDTH + 10;
    localparam int PROD_W = DATA_WIDTH + 10;
    localparam int MAG_W  = (DATA_WIDTH > mmau_pkg::THR_W) ? DATA_WIDTH : mmau_pkg::THR_W;
    localparam int NSTG   = mmau_pkg::SRCH_STEPS + 6;
    localparam int S_LAST = mmau_pkg::SRCH_STEPS;

    localparam logic signed [RES_W-1:0] SAT_HI = {{(RES_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

    // Word as taken from the ports.
    typedef struct packed {
        logic signed [DW-1:0]               s;
        logic                               last;
        logic [mmau_pkg::MODE_W-1:0]        mode;
    } in_t;

    // Word traveling through the threshold search.
    typedef struct packed {
        logic signed [DW-1:0]               s;
        logic                               last;
        logic [mmau_pkg::MODE_W-1:0]        mode;
        logic                               neg;
        logic                               big;
        logic [mmau_pkg::THR_W-1:0]         m;
        logic                               tsel;
        logic [mmau_pkg::VAL_W-1:0]         hsig;
        logic [mmau_pkg::CNT_W-1:0]         pos;
    } srch_t;

    // Result picked per mode, with the multiplier operand for silu and hard swish.
    typedef struct packed {
        logic signed [DW-1:0]               s;
        logic                               last;
        logic [mmau_pkg::MODE_W-1:0]        mode;
        logic                               use_mul;
        logic [mmau_pkg::VAL_W-1:0]         factor;
        logic signed [RES_W-1:0]            direct;
    } fin_t;

    typedef struct packed {
        logic                               last;
        logic [mmau_pkg::MODE_W-1:0]        mode;
        logic                               use_mul;
        logic signed [PROD_W-1:0]           prod;
        logic signed [RES_W-1:0]            direct;
    } mul_t;

    typedef struct packed {
        logic                               last;
        logic [mmau_pkg::MODE_W-1:0]        mode;
        logic signed [RES_W-1:0]            val;
    } rnd_t;

    logic                                   accept;
    logic                                   cfg_wr;
    logic [mmau_pkg::MODE_W-1:0]            mode_reg;
    logic [mmau_pkg::MODE_W-1:0]            mode_next;
    logic [NSTG-1:0]                        vld_reg;
    logic [NSTG-1:0]                        vld_next;

    in_t                                    in_reg;
    srch_t                                  srch_reg [0:S_LAST];
    srch_t                                  pre_next;
    fin_t                                   fin_reg;
    fin_t                                   fin_next;
    mul_t                                   mul_reg;
    mul_t                                   mul_next;
    rnd_t                                   rnd_reg;
    rnd_t                                   rnd_next;
    logic signed [DW-1:0]                   sample_out_reg;
    logic signed [DW-1:0]                   sample_out_next;
    logic                                   last_out_reg;
    logic [mmau_pkg::MODE_W-1:0]            out_mode_reg;

    // ------------------------------------------------------------------
    // Handshake and configuration port
    // ------------------------------------------------------------------

    // The receiver cannot hold results off, so nothing ever backs up into the input.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr && (paddr[2] == mmau_pkg::REG_IDX_MODE))
        begin
            mode_next = pwdata[mmau_pkg::MODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == mmau_pkg::REG_IDX_MODE)
        begin
            prdata = mmau_pkg::CFG_DATA_W'(mode_reg);
        end
    end

    // Valid bits move one stage per clock alongside the payload.
    assign vld_next = {vld_reg[NSTG-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            vld_reg  <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register. The mode travels with the word.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        in_reg.s    <= sample_in;
        in_reg.last <= last_in;
        in_reg.mode <= mode_reg;
    end

    // ------------------------------------------------------------------
    // Stage 1: sign and magnitude, large-magnitude check, hard sigmoid.
    // ------------------------------------------------------------------
    logic                                   neg1;
    logic [DW-1:0]                          mag1;
    logic [MAG_W-1:0]                       mag_ext1;
    logic                                   big1;
    logic signed [RES_W-1:0]                se1;
    logic [mmau_pkg::HS_N_W-1:0]            hs_n1;
    logic [mmau_pkg::HS_P_W-1:0]            hs_p1;
    logic [mmau_pkg::VAL_W-1:0]             hsig1;

    always_comb
    begin
        neg1     = in_reg.s[DW-1];
        mag1     = neg1 ? DW'(-in_reg.s) : DW'(in_reg.s);
        mag_ext1 = MAG_W'(mag1);
        big1     = (mag_ext1 >= MAG_W'(mmau_pkg::LIMIT_MAG));
        se1      = RES_W'($signed(in_reg.s));

        // Hard sigmoid: (x + 3) / 6 clamped to 0..1, numerator biased by 3 to round.
        hs_n1 = mmau_pkg::HS_N_W'(se1 + RES_W'(mmau_pkg::HS_BIAS));
        hs_p1 = mmau_pkg::HS_P_W'(hs_n1) * mmau_pkg::HS_P_W'(mmau_pkg::HS_RECIP);
        if (se1 >= RES_W'(mmau_pkg::THREE_Q))
        begin
            hsig1 = mmau_pkg::VAL_W'(mmau_pkg::ONE_Q);
        end
        else if (se1 < RES_W'(-mmau_pkg::THREE_Q))
        begin
            hsig1 = '0;
        end
        else
        begin
            hsig1 = mmau_pkg::VAL_W'(hs_p1 >> mmau_pkg::HS_SHIFT);
        end

        pre_next.s    = in_reg.s;
        pre_next.last = in_reg.last;
        pre_next.mode = in_reg.mode;
        pre_next.neg  = neg1;
        pre_next.big  = big1;
        pre_next.m    = big1 ? '0 : mag_ext1[mmau_pkg::THR_W-1:0];
        pre_next.tsel = (in_reg.mode == mmau_pkg::MODE_TANH);
        pre_next.hsig = hsig1;
        pre_next.pos  = '0;
    end

    always_ff @(posedge clk)
    begin
        srch_reg[0] <= pre_next;
    end

    // ------------------------------------------------------------------
    // Stages 2..10: binary search for the number of thresholds at or below the magnitude.
    // Eight halving steps settle the index; a last step adds the top entry.
    // ------------------------------------------------------------------
    for (genvar g = 1; g <= S_LAST; g++)
    begin : g_srch
        srch_t                              step_next;
        logic [mmau_pkg::TAB_IDX_W-1:0]     probe;
        logic [mmau_pkg::THR_W-1:0]         thr;
        logic                               hit;

        if (g < S_LAST)
        begin : g_step
            localparam int BIT = S_LAST - 1 - g;

            always_comb
            begin
                probe = srch_reg[g-1].pos[mmau_pkg::TAB_IDX_W-1:0]
                        | mmau_pkg::TAB_IDX_W'((1 << BIT) - 1);
                thr   = srch_reg[g-1].tsel ? mmau_pkg::TANH_THR[probe]
                                           : mmau_pkg::SIG_THR[probe];
                hit   = (thr <= srch_reg[g-1].m);
                step_next = srch_reg[g-1];
                if (hit)
                begin
                    step_next.pos = srch_reg[g-1].pos | (mmau_pkg::CNT_W'(1) << BIT);
                end
            end
        end
        else
        begin : g_last
            always_comb
            begin
                probe = srch_reg[g-1].pos[mmau_pkg::TAB_IDX_W-1:0];
                thr   = srch_reg[g-1].tsel ? mmau_pkg::TANH_THR[probe]
                                           : mmau_pkg::SIG_THR[probe];
                hit   = (thr <= srch_reg[g-1].m);
                step_next     = srch_reg[g-1];
                step_next.pos = srch_reg[g-1].pos + mmau_pkg::CNT_W'(hit);
            end
        end

        always_ff @(posedge clk)
        begin
            srch_reg[g] <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: form sigmoid and tanh from the count and pick the result per mode.
    // ------------------------------------------------------------------
    logic [mmau_pkg::VAL_W-1:0]             sig_a;
    logic [mmau_pkg::VAL_W-1:0]             tmag_a;
    logic signed [RES_W-1:0]                se_a;
    logic signed [RES_W-1:0]                tanh_a;

    always_comb
    begin
        // Sigmoid of a negative input is one minus that of its magnitude.
        if (srch_reg[S_LAST].big)
        begin
            sig_a = srch_reg[S_LAST].neg ? '0 : mmau_pkg::VAL_W'(mmau_pkg::ONE_Q);
        end
        else if (srch_reg[S_LAST].neg)
        begin
            sig_a = mmau_pkg::VAL_W'(mmau_pkg::HALF_Q) - srch_reg[S_LAST].pos;
        end
        else
        begin
            sig_a = mmau_pkg::VAL_W'(mmau_pkg::HALF_Q) + srch_reg[S_LAST].pos;
        end

        tmag_a = srch_reg[S_LAST].big ? mmau_pkg::VAL_W'(mmau_pkg::ONE_Q)
                                      : srch_reg[S_LAST].pos;
        tanh_a = srch_reg[S_LAST].neg ? -RES_W'(tmag_a) : RES_W'(tmag_a);
        se_a   = RES_W'($signed(srch_reg[S_LAST].s));

        fin_next.s       = srch_reg[S_LAST].s;
        fin_next.last    = srch_reg[S_LAST].last;
        fin_next.mode    = srch_reg[S_LAST].mode;
        fin_next.use_mul = 1'b0;
        fin_next.factor  = '0;
        fin_next.direct  = '0;

        case (srch_reg[S_LAST].mode)
            mmau_pkg::MODE_RELU:
            begin
                fin_next.direct = (se_a > 0) ? se_a : '0;
            end
            mmau_pkg::MODE_RELU6:
            begin
                if (se_a <= 0)
                begin
                    fin_next.direct = '0;
                end
                else if (se_a < RES_W'(mmau_pkg::SIX_Q))
                begin
                    fin_next.direct = se_a;
                end
                else
                begin
                    fin_next.direct = RES_W'(mmau_pkg::SIX_Q);
                end
            end
            mmau_pkg::MODE_SIGM:
            begin
                fin_next.direct = RES_W'(sig_a);
            end
            mmau_pkg::MODE_SILU:
            begin
                fin_next.use_mul = 1'b1;
                fin_next.factor  = sig_a;
            end
            mmau_pkg::MODE_HSIGM:
            begin
                fin_next.direct = RES_W'(srch_reg[S_LAST].hsig);
            end
            mmau_pkg::MODE_HSWISH:
            begin
                fin_next.use_mul = 1'b1;
                fin_next.factor  = srch_reg[S_LAST].hsig;
            end
            mmau_pkg::MODE_TANH:
            begin
                fin_next.direct = tanh_a;
            end
            default:
            begin
                fin_next.direct = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 12: x times the gate for silu and hard swish.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_next.last    = fin_reg.last;
        mul_next.mode    = fin_reg.mode;
        mul_next.use_mul = fin_reg.use_mul;
        mul_next.direct  = fin_reg.direct;
        mul_next.prod    = $signed(PROD_W'($signed(fin_reg.s)))
                           * $signed(PROD_W'({1'b0, fin_reg.factor}));
    end

    // ------------------------------------------------------------------
    // Stage 13: scale the product back, rounding the magnitude half up.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]                      pmag_c;
    logic [PROD_W-1:0]                      prnd_c;

    always_comb
    begin
        pmag_c = mul_reg.prod[PROD_W-1] ? PROD_W'(-mul_reg.prod) : PROD_W'(mul_reg.prod);
        prnd_c = (pmag_c + PROD_W'(mmau_pkg::HALF_Q)) >> mmau_pkg::FRAC_BITS;

        rnd_next.last = mul_reg.last;
        rnd_next.mode = mul_reg.mode;
        if (!mul_reg.use_mul)
        begin
            rnd_next.val = mul_reg.direct;
        end
        else if (mul_reg.prod[PROD_W-1])
        begin
            rnd_next.val = -$signed(RES_W'(prnd_c));
        end
        else
        begin
            rnd_next.val = $signed(RES_W'(prnd_c));
        end
    end

    // ------------------------------------------------------------------
    // Stage 14: saturate to the output width.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (rnd_reg.val > SAT_HI)
        begin
            sample_out_next = SAT_HI[DW-1:0];
        end
        else if (rnd_reg.val < SAT_LO)
        begin
            sample_out_next = SAT_LO[DW-1:0];
        end
        else
        begin
            sample_out_next = rnd_reg.val[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg        <= fin_next;
        mul_reg        <= mul_next;
        rnd_reg        <= rnd_next;
        sample_out_reg <= sample_out_next;
        last_out_reg   <= rnd_reg.last;
        out_mode_reg   <= rnd_reg.mode;
    end

    assign done       = vld_reg[NSTG-1];
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every result belongs to a word taken a fixed pipeline depth earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, NSTG))
        else $error("result without a word taken %0d cycles earlier", NSTG);

    // The sigmoid search never counts past the real half of its table.
    a_sig_count: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_LAST+1] && !srch_reg[S_LAST].tsel)
        |-> (srch_reg[S_LAST].pos <= mmau_pkg::CNT_W'(mmau_pkg::HALF_Q)))
        else $error("sigmoid threshold count out of range");

    // Relu, relu6, sigmoid and hard sigmoid never give a negative word.
    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_mode_reg == mmau_pkg::MODE_RELU
               || out_mode_reg == mmau_pkg::MODE_RELU6
               || out_mode_reg == mmau_pkg::MODE_SIGM
               || out_mode_reg == mmau_pkg::MODE_HSIGM))
        |-> !sample_out[DW-1])
        else $error("negative result in a nonnegative mode");

endmodule

/* verif/multi_mode_activation_unit_checker.sv */
// Result checker for the multi-mode activation unit: mode tracking, prediction and comparison.
`timescale 1ns / 100ps

module multi_mode_activation_unit_checker #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [DATA_WIDTH-1:0]        sample_in,
    input  logic                                last_in,
    input  logic                                done,
    input  logic signed [DATA_WIDTH-1:0]        sample_out,
    input  logic                                last_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mmau_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mmau_pkg::CFG_DATA_W-1:0]     pwdata,
    input  logic [mmau_pkg::CFG_DATA_W-1:0]     prdata,
    input  logic                                pready,
    output int                                  mismatch_count,
    output int                                  words_in_flight
);
    import mmau_pkg::*;

    localparam logic [63:0] Q62_ONE          = 64'h4000_0000_0000_0000;
    localparam int          SERIES_TERMS     = 60;
    localparam int          REDUCE_SQUARINGS = 5;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] sample;
        logic                  last;
    } act_word_t;

    act_word_t             expected_words[$];
    act_word_t             oldest;
    act_word_t             predicted;
    logic [MODE_W-1:0]     mode_q;

    // Product of two Q62 numbers, truncated back to Q62.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // e^(-mag / 2^FRAC_BITS) in Q62: series on a reduced argument, then repeated squaring.
    function automatic logic [63:0] exp_neg_q62(input logic [63:0] mag);
        logic [63:0] x;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] y;
        int          k;
        x    = mag << (62 - FRAC_BITS - REDUCE_SQUARINGS);
        pos  = Q62_ONE;
        neg  = '0;
        term = Q62_ONE;
        k    = 1;
        while (k <= SERIES_TERMS)
        begin
            term = q62_mul(term, x) / 64'(k);
            if (term == '0)
            begin
                k = SERIES_TERMS + 1;
            end
            else
            begin
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
                k++;
            end
        end
        y = pos - neg;
        for (int i = 0; i < REDUCE_SQUARINGS; i++)
            y = q62_mul(y, y);
        return y;
    endfunction

    function automatic int sigmoid_level(input int s);
        logic [63:0] mag;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] q2;
        mag = 64'(s < 0 ? -s : s);
        if (mag >= 64'(LIMIT_MAG))
            return s >= 0 ? ONE_Q : 0;
        e = exp_neg_q62(mag) >> 22;
        d = (64'd1 << 40) + e;
        if (s >= 0)
            q2 = (64'd1 << (FRAC_BITS + 41)) / d;
        else
            q2 = (e << (FRAC_BITS + 1)) / d;
        return int'((q2 + 1) >> 1);
    endfunction

    function automatic int tanh_level(input int s);
        logic [63:0] mag;
        logic [63:0] ex;
        logic [63:0] e2;
        logic [63:0] q2;
        logic [63:0] r;
        mag = 64'(s < 0 ? -s : s);
        if (mag >= 64'(LIMIT_MAG))
        begin
            r = 64'(ONE_Q);
        end
        else
        begin
            ex = exp_neg_q62(mag);
            e2 = q62_mul(ex, ex) >> 22;
            q2 = (((64'd1 << 40) - e2) << (FRAC_BITS + 1)) / ((64'd1 << 40) + e2);
            r  = (q2 + 1) >> 1;
        end
        return s < 0 ? -int'(r) : int'(r);
    endfunction

    function automatic int hard_sigmoid_level(input int s);
        if (s >= THREE_Q)
            return ONE_Q;
        if (s < -THREE_Q)
            return 0;
        return (s + THREE_Q + 3) / 6;
    endfunction

    // Drops the fraction bits of a product, rounding half away from zero.
    function automatic int round_product(input int p);
        int mag;
        mag = p < 0 ? -p : p;
        mag = (mag + HALF_Q) >> FRAC_BITS;
        return p < 0 ? -mag : mag;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] predict_activation(
        input logic [MODE_W-1:0] mode,
        input int                s
    );
        int r;
        int hi;
        int lo;
        case (mode)
            MODE_RELU:   r = s > 0 ? s : 0;
            MODE_RELU6:  r = s > 0 ? (s < SIX_Q ? s : SIX_Q) : 0;
            MODE_SIGM:   r = sigmoid_level(s);
            MODE_SILU:   r = round_product(s * sigmoid_level(s));
            MODE_HSIGM:  r = hard_sigmoid_level(s);
            MODE_HSWISH: r = round_product(s * hard_sigmoid_level(s));
            MODE_TANH:   r = tanh_level(s);
            default:     r = 0;
        endcase
        hi = (1 << (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (r > hi)
            r = hi;
        else if (r < lo)
            r = lo;
        return DATA_WIDTH'(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            mode_q          = MODE_RELU;
            words_in_flight = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_IDX_MODE)
            begin
                if (pwrite)
                begin
                    mode_q = pwdata[MODE_W-1:0];
                end
                else if (prdata[MODE_W-1:0] !== mode_q)
                begin
                    $error("mode readback: expected %0d, actual %0d",
                           mode_q, prdata[MODE_W-1:0]);
                    mismatch_count++;
                end
            end

            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result with no word outstanding: sample_out %0d, last_out %0b",
                           sample_out, last_out);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    if (sample_out !== oldest.sample)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(oldest.sample), sample_out);
                        mismatch_count++;
                    end
                    if (last_out !== oldest.last)
                    begin
                        $error("last_out: expected %0b, actual %0b", oldest.last, last_out);
                        mismatch_count++;
                    end
                end
            end

            if (start && !busy)
            begin
                predicted.sample = predict_activation(mode_q, sample_in);
                predicted.last   = last_in;
                expected_words.push_back(predicted);
            end

            words_in_flight = expected_words.size();
        end
    end

endmodule

/* verif/multi_mode_activation_unit_test.sv */
// Testbench top for the multi-mode activation unit: stimulus, mode setup and verdict.
`timescale 1ns / 100ps

module multi_mode_activation_unit_test;
    import mmau_pkg::*;

    localparam int DATA_W          = 16;
    // The pipeline is 15 stages deep; the flush wait at the end gives it some margin.
    localparam int FLUSH_CYCLES    = 20;
    // Longest honest quiet stretch is a sender gap or a pipeline drain, both far below this limit.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MODE_COUNT      = 1 << MODE_W;
    localparam int RANDOM_PHASES   = 16;
    localparam int WORDS_PER_PHASE = 112;
    localparam int MAX_BURST       = 48;
    localparam int MAX_GAP         = 12;

    // Code 7 has no name in the package; the unit must return zero for it.
    localparam logic [MODE_W-1:0]     MODE_UNUSED = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MODE   = CFG_ADDR_W'(4 * REG_IDX_MODE);
    // Register index one does not exist, so a write there must leave the mode alone.
    localparam logic [CFG_ADDR_W-1:0] ADDR_NO_REG = CFG_ADDR_W'(4 * (REG_IDX_MODE + 1));

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] sample_in;
    logic                     last_in;
    logic                     done;
    logic signed [DATA_W-1:0] sample_out;
    logic                     last_out;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0]    pwdata;
    logic [CFG_DATA_W-1:0]    prdata;
    logic                     pready;
    int                       mismatch_count;
    int                       words_in_flight;
    int                       quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_mode_activation_unit #(
        .DATA_WIDTH (DATA_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample_in  (sample_in),
        .last_in    (last_in),
        .done       (done),
        .sample_out (sample_out),
        .last_out   (last_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // The checker sits beside the unit, sees every port and owns all comparisons.
    multi_mode_activation_unit_checker #(
        .DATA_WIDTH (DATA_W)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sample_in       (sample_in),
        .last_in         (last_in),
        .done            (done),
        .sample_out      (sample_out),
        .last_out        (last_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    function automatic logic [MODE_W-1:0] mode_by_index(input int idx);
        case (idx)
            0:       return MODE_RELU;
            1:       return MODE_RELU6;
            2:       return MODE_SIGM;
            3:       return MODE_SILU;
            4:       return MODE_HSIGM;
            5:       return MODE_HSWISH;
            6:       return MODE_TANH;
            default: return MODE_UNUSED;
        endcase
    endfunction

    // Samples on the edges of the activations, in Q8.8: the range ends, zero and one step
    // around it, one half, the hard sigmoid knees at plus and minus three, the relu6 clamp
    // at six, and the magnitude of 24 where sigmoid and tanh switch to their exact limits.
    function automatic logic signed [DATA_W-1:0] boundary_sample(input int unsigned pick);
        case (pick % 24)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 0;
            3:       return 1;
            4:       return -1;
            5:       return 128;
            6:       return -128;
            7:       return 767;
            8:       return 768;
            9:       return 769;
            10:      return -767;
            11:      return -768;
            12:      return -769;
            13:      return 1535;
            14:      return 1536;
            15:      return 1537;
            16:      return 6143;
            17:      return 6144;
            18:      return -6144;
            19:      return -6145;
            20:      return -6143;
            21:      return -2;
            22:      return 255;
            default: return 256;
        endcase
    endfunction

    // Most samples land where the curves actually bend; the rest spread over the full range
    // so that every bit of the word toggles.
    function automatic logic signed [DATA_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 11);
        if (pick < 2)
            return boundary_sample($urandom);
        else if (pick < 6)
            return DATA_W'($urandom_range(0, 2 * LIMIT_MAG - 1) - LIMIT_MAG);
        else if (pick < 8)
            return DATA_W'($urandom_range(0, 2047) - 1024);
        else
            return DATA_W'($urandom);
    endfunction

    // Register transfers: a setup phase, then an access phase that ends when pready is high.
    // An idle phase follows so that the next transfer never toggles psel within a step.
    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // The checker compares the returned value; the task only runs the transfer.
    task automatic reg_read(input logic [CFG_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The unused upper data bits carry noise, since only the low mode bits are stored.
    task automatic set_mode(input logic [MODE_W-1:0] code);
        logic [CFG_DATA_W-1:0] data;
        data             = $urandom;
        data[MODE_W-1:0] = code;
        reg_write(ADDR_MODE, data);
        reg_read(ADDR_MODE);
    endtask

    // Holds the word on the ports until the unit takes it. start stays high on return so
    // that a following word in the same burst goes out back to back.
    task automatic send_word(input logic signed [DATA_W-1:0] value, input logic flag);
        start     <= 1'b1;
        sample_in <= value;
        last_in   <= flag;
        do @(posedge clk); while (busy);
    endtask

    // Stops sending and waits until every word taken so far has come back. The first edge
    // lets the checker record a word taken at the current edge before the count is read.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
    endtask

    // Sends random words in bursts of random length separated by random gaps, optionally
    // with no gaps at all, or with a full drain halfway through.
    task automatic send_stream(input int count, input bit gapless, input bit drain_midway);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, MAX_BURST);
        for (int n = 0; n < count; n++)
        begin
            send_word(random_sample(), 1'($urandom_range(0, 1)));
            if (drain_midway && n == count / 2)
            begin
                drain_pipeline();
            end
            else
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, MAX_BURST);
                    gap = (gapless || $urandom_range(0, 3) == 0) ? 0
                                                                 : $urandom_range(1, MAX_GAP);
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end
        drain_pipeline();
    endtask

    // Watchdog: counts edges at which no word, result or register transfer completes.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("multi_mode_activation_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        int pick;
        rst_n     = 1'b0;
        start     = 1'b0;
        sample_in = '0;
        last_in   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The mode must read back as relu after reset, and the first words run under it
        // without any write.
        reg_read(ADDR_MODE);

        // Directed part: every mode code, the unused one included, sees both range ends
        // and one sample on the edge that matters most for that mode.
        for (int m = 0; m < MODE_COUNT; m++)
        begin
            if (m != 0)
                set_mode(mode_by_index(m));
            send_word(16'sh8000, 1'b0);
            send_word(16'sh7FFF, 1'b1);
            case (m)
                0:       pick = 2;
                1:       pick = 15;
                2:       pick = 17;
                3:       pick = 19;
                4:       pick = 12;
                5:       pick = 8;
                6:       pick = 18;
                default: pick = 3;
            endcase
            send_word(boundary_sample(pick), 1'b0);
            drain_pipeline();
        end

        // Random part: each mode once in order, then modes at random. Some phases run
        // without gaps, some drain the pipeline halfway, and one phase also writes the
        // register that does not exist and reads the mode back to see it unchanged.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_mode(mode_by_index(p < MODE_COUNT ? p : $urandom_range(0, MODE_COUNT - 1)));
            if (p == 5)
            begin
                reg_write(ADDR_NO_REG, $urandom);
                reg_read(ADDR_MODE);
            end
            send_stream(WORDS_PER_PHASE, p % 5 == 2, p % 3 == 0);
        end

        // Everything has drained; let a few more cycles pass for any stray result.
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("multi_mode_activation_unit_test: PASS");
        else
            $display("multi_mode_activation_unit_test: FAIL");
        $finish;
    end

endmodule
